/* design/csed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacitive sense event detector package
// Shared constants, widths and types for the capacitive sense baseline event
// detector with event-rate averaging.
// ----------------------------------------------------------------------------
package csed_pkg;

   // Structure of the filters and of the event window.
   localparam int WINDOW_SECONDS = 12;
   localparam int AVERAGE_SHIFT  = 7;
   localparam int BASELINE_SHIFT = 8;
   localparam int RATE_SHIFT     = 2;

   // Field and accumulator widths.
   localparam int LEVEL_W     = 16;
   localparam int AVG_W       = LEVEL_W + AVERAGE_SHIFT;
   localparam int BASE_W      = LEVEL_W + BASELINE_SHIFT;
   localparam int DIFF_W      = LEVEL_W + 2;
   localparam int CFG_W       = 16;
   localparam int CFG_INDEX_W = 2;
   localparam int TICK_W      = 16;
   localparam int EVENTS_W    = 8;
   localparam int EVENTS_MAX  = (1 << EVENTS_W) - 1;
   localparam int TOTAL_W     = $clog2(WINDOW_SECONDS * EVENTS_MAX + 1);
   localparam int HEAD_W      = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
   localparam int RATE_W      = 16;

   // Reported rate is rate_acc * 100 / (WINDOW_SECONDS << RATE_SHIFT), done as
   // a multiply by a rounded-up reciprocal. The fraction width keeps the
   // reciprocal error below one step of the divisor for any 16-bit input.
   localparam longint RATE_PERCENT = 100;
   localparam longint RATE_DIV     = longint'(WINDOW_SECONDS) << RATE_SHIFT;
   localparam int     RATE_FRAC_W  = RATE_W + 1 + $clog2(RATE_DIV);
   localparam longint RATE_MUL     =
      ((RATE_PERCENT << RATE_FRAC_W) + RATE_DIV - 1) / RATE_DIV;
   localparam int     RATE_MUL_W   = $clog2(RATE_MUL + 1);
   localparam int     RATE_PROD_W  =
      ((RATE_W + RATE_MUL_W) > (RATE_FRAC_W + RATE_W + 1)) ?
      (RATE_W + RATE_MUL_W) : (RATE_FRAC_W + RATE_W + 1);

   // Configuration register set.
   typedef struct packed {
      logic [CFG_W-1:0] detect_threshold;
      logic [CFG_W-1:0] release_threshold;
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] ticks_per_second;
   } cfg_type;

   // Filter and detector state as seen by the output stage.
   typedef struct packed {
      logic               detected;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] baseline;
   } filter_status_type;

   // Event-rate state as seen by the output stage.
   typedef struct packed {
      logic              second_done;
      logic [RATE_W-1:0] rate_acc;
   } rate_status_type;

endpackage

/* design/csed_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture filter and event detector
// Leaky average of the capture count, slower baseline of that average, and a
// hysteresis detector with a saturating debounce counter on their difference.
// ----------------------------------------------------------------------------
module csed_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [csed_pkg::LEVEL_W-1:0]          capture_count,
   input  csed_pkg::cfg_type                     cfg,
   output logic                                  event_start,
   output csed_pkg::filter_status_type           status
);
   import csed_pkg::*;

   logic [AVG_W-1:0]   average_acc_ff, average_acc_in;
   logic [BASE_W-1:0]  baseline_acc_ff, baseline_acc_in;
   logic               detected_ff, detected_in;
   logic [CFG_W-1:0]   debounce_ff, debounce_in;
   logic [CFG_W-1:0]   debounce_inc;
   logic [LEVEL_W-1:0] level;
   logic [LEVEL_W-1:0] baseline;
   logic signed [DIFF_W-1:0] diff;
   logic               detect_hit;
   logic               release_hit;

   // Leaky average and baseline, both wrapping at their accumulator width.
   always_comb begin
      average_acc_in  = average_acc_ff - (average_acc_ff >> AVERAGE_SHIFT)
                        + AVG_W'(capture_count);
      level           = average_acc_in[AVG_W-1:AVERAGE_SHIFT];
      baseline_acc_in = baseline_acc_ff - (baseline_acc_ff >> BASELINE_SHIFT)
                        + BASE_W'(level);
      baseline        = baseline_acc_in[BASE_W-1:BASELINE_SHIFT];
      diff            = $signed({2'b00, level}) - $signed({2'b00, baseline});
   end

   // Hysteresis comparisons against the zero-extended thresholds.
   assign detect_hit  = diff > $signed({2'b00, cfg.detect_threshold});
   assign release_hit = diff < $signed({2'b00, cfg.release_threshold});
   assign debounce_inc = (debounce_ff == '1) ? debounce_ff : debounce_ff + 1'b1;

   // Detector state: set on a rise above the detect threshold, clear only
   // after the debounce period once the difference falls below release.
   always_comb begin
      detected_in = detected_ff;
      debounce_in = debounce_ff;
      event_start = 1'b0;
      if (!detected_ff) begin
         if (detect_hit) begin
            detected_in = 1'b1;
            debounce_in = '0;
            event_start = step;
         end
      end else begin
         debounce_in = debounce_inc;
         if ((debounce_inc >= cfg.debounce_ticks) && release_hit) begin
            detected_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         average_acc_ff  <= '0;
         baseline_acc_ff <= '0;
         detected_ff     <= 1'b0;
         debounce_ff     <= '0;
      end else if (step) begin
         average_acc_ff  <= average_acc_in;
         baseline_acc_ff <= baseline_acc_in;
         detected_ff     <= detected_in;
         debounce_ff     <= debounce_in;
      end
   end

   // The stored state is the result of the last word.
   assign status.detected = detected_ff;
   assign status.level    = average_acc_ff[AVG_W-1:AVERAGE_SHIFT];
   assign status.baseline = baseline_acc_ff[BASE_W-1:BASELINE_SHIFT];

endmodule

/* design/csed_rate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event-rate accumulator
// Counts detector events per second, keeps a ring of per-second counts with a
// running window total, and updates a rounded leaky rate average each second.
// ----------------------------------------------------------------------------
module csed_rate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              event_start,
   input  logic [csed_pkg::CFG_W-1:0]        ticks_per_second,
   output csed_pkg::rate_status_type         status
);
   import csed_pkg::*;

   localparam int NEXT_W   = RATE_W + 2;
   localparam int ROUND_HALF = 1 << (RATE_SHIFT - 1);

   logic [EVENTS_W-1:0] second_events_ff, second_events_in;
   logic [EVENTS_W-1:0] events_ring_ff [WINDOW_SECONDS];
   logic [HEAD_W-1:0]   ring_head_ff, ring_head_in;
   logic [TOTAL_W-1:0]  window_total_ff, window_total_in;
   logic [RATE_W-1:0]   rate_acc_ff, rate_acc_in;
   logic [TICK_W-1:0]   tick_divider_ff, tick_divider_in;
   logic                second_done_ff;
   logic [EVENTS_W-1:0] events_now;
   logic [TICK_W:0]     tick_inc;
   logic                close_second;
   logic [NEXT_W-1:0]   round_part;
   logic [NEXT_W-1:0]   rate_sum;
   logic [NEXT_W-1:0]   rate_dec;
   logic [NEXT_W-1:0]   rate_next;

   // Events of the current second, counting the one that starts now.
   assign events_now = (event_start && (second_events_ff != EVENTS_W'(EVENTS_MAX))) ?
                       second_events_ff + 1'b1 : second_events_ff;

   // Tick divider closes a second once the count reaches ticks per second.
   assign tick_inc     = {1'b0, tick_divider_ff} + 1'b1;
   assign close_second = tick_inc >= {1'b0, ticks_per_second};
   assign tick_divider_in = close_second ? '0 : tick_inc[TICK_W-1:0];

   // Ring slot replacement and running window total.
   always_comb begin
      second_events_in = events_now;
      window_total_in  = window_total_ff;
      ring_head_in     = ring_head_ff;
      if (close_second) begin
         second_events_in = '0;
         window_total_in  = window_total_ff - TOTAL_W'(events_ring_ff[ring_head_ff])
                            + TOTAL_W'(events_now);
         ring_head_in     = (ring_head_ff == HEAD_W'(WINDOW_SECONDS - 1)) ?
                            '0 : ring_head_ff + 1'b1;
      end
   end

   // Rounded leaky rate average; an empty window decays one extra count.
   always_comb begin
      round_part = (NEXT_W'(rate_acc_ff) + NEXT_W'(ROUND_HALF)) >> RATE_SHIFT;
      rate_sum   = NEXT_W'(rate_acc_ff) + NEXT_W'(window_total_in);
      rate_dec   = round_part + NEXT_W'(rate_acc_ff != '0);
      if (window_total_in != '0) begin
         rate_next = (rate_sum > round_part) ? rate_sum - round_part : '0;
      end else begin
         rate_next = (NEXT_W'(rate_acc_ff) > rate_dec) ?
                     NEXT_W'(rate_acc_ff) - rate_dec : '0;
      end
      if (close_second) begin
         rate_acc_in = (rate_next > NEXT_W'({RATE_W{1'b1}})) ?
                       '1 : rate_next[RATE_W-1:0];
      end else begin
         rate_acc_in = rate_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_events_ff <= '0;
         ring_head_ff     <= '0;
         window_total_ff  <= '0;
         rate_acc_ff      <= '0;
         tick_divider_ff  <= '0;
         second_done_ff   <= 1'b0;
         for (int i = 0; i < WINDOW_SECONDS; i++) begin
            events_ring_ff[i] <= '0;
         end
      end else if (step) begin
         second_events_ff <= second_events_in;
         ring_head_ff     <= ring_head_in;
         window_total_ff  <= window_total_in;
         rate_acc_ff      <= rate_acc_in;
         tick_divider_ff  <= tick_divider_in;
         second_done_ff   <= close_second;
         if (close_second) begin
            events_ring_ff[ring_head_ff] <= events_now;
         end
      end
   end

   assign status.second_done = second_done_ff;
   assign status.rate_acc    = rate_acc_ff;

endmodule

/* design/cap_sense_event_rate_detector.sv */
`timescale 1ns / 1ps
// Path: a result word passes the input register, the state update and the output
// register with rate scaling after its input word is accepted.
// Throughput: one word per cycle; the input side keeps accepting while a
// result waits, until the input and state stages are both occupied.
// Reset: synchronous, active high; clears all filter, detector and rate state
// and loads the default configuration.
// ----------------------------------------------------------------------------
// Capacitive sense event rate detector
// Top level: valid/stall pipeline, configuration registers, filter and rate
// units, and the scaling of the rate average into hundredths of hertz.
// ----------------------------------------------------------------------------
module cap_sense_event_rate_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [csed_pkg::LEVEL_W-1:0]       req_capture_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_event_active,
   output logic [csed_pkg::LEVEL_W-1:0]       rsp_raw_level,
   output logic [csed_pkg::LEVEL_W-1:0]       rsp_baseline_level,
   output logic [csed_pkg::RATE_W-1:0]        rsp_event_rate,
   output logic                               rsp_second_done,
   input  logic                               csr_write_enable,
   input  logic [csed_pkg::CFG_INDEX_W-1:0]   csr_index,
   input  logic [csed_pkg::CFG_W-1:0]         csr_write_data
);
   import csed_pkg::*;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CSR_DETECT_THRESHOLD  = 2'd0,
      CSR_RELEASE_THRESHOLD = 2'd1,
      CSR_DEBOUNCE_TICKS    = 2'd2,
      CSR_TICKS_PER_SECOND  = 2'd3
   } csr_index_type;

   localparam int QUOT_W = RATE_PROD_W - RATE_FRAC_W;

   cfg_type             cfg_ff;
   logic                in_valid_ff;
   logic [LEVEL_W-1:0]  capture_ff;
   logic                state_valid_ff;
   logic                rsp_valid_ff;
   logic                rsp_event_active_ff;
   logic [LEVEL_W-1:0]  rsp_raw_level_ff;
   logic [LEVEL_W-1:0]  rsp_baseline_level_ff;
   logic [RATE_W-1:0]   rsp_event_rate_ff, rsp_event_rate_in;
   logic                rsp_second_done_ff;
   logic                out_advance;
   logic                state_advance;
   logic                in_advance;
   logic                step;
   logic                event_start;
   filter_status_type   filter_status;
   rate_status_type     rate_status;
   logic [RATE_PROD_W-1:0] rate_prod;
   logic [QUOT_W-1:0]   rate_quot;

   // Each stage moves on when it is empty or its successor moves on.
   assign out_advance   = !rsp_valid_ff || !rsp_stall;
   assign state_advance = !state_valid_ff || out_advance;
   assign in_advance    = !in_valid_ff || state_advance;
   assign step          = in_valid_ff && state_advance;
   assign req_stall     = !in_advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold  <= CFG_W'(16);
         cfg_ff.release_threshold <= CFG_W'(4);
         cfg_ff.debounce_ticks    <= CFG_W'(250);
         cfg_ff.ticks_per_second  <= CFG_W'(500);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DETECT_THRESHOLD:  cfg_ff.detect_threshold  <= csr_write_data;
            CSR_RELEASE_THRESHOLD: cfg_ff.release_threshold <= csr_write_data;
            CSR_DEBOUNCE_TICKS:    cfg_ff.debounce_ticks    <= csr_write_data;
            CSR_TICKS_PER_SECOND:  cfg_ff.ticks_per_second  <= csr_write_data;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_advance) begin
         capture_ff <= req_capture_count;
      end
   end

   // State stage: the filter and rate units hold the updated state.
   csed_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .capture_count (capture_ff),
      .cfg           (cfg_ff),
      .event_start   (event_start),
      .status        (filter_status)
   );

   csed_rate u_rate (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .event_start      (event_start),
      .ticks_per_second (cfg_ff.ticks_per_second),
      .status           (rate_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_valid_ff <= 1'b0;
      end else if (state_advance) begin
         state_valid_ff <= in_valid_ff;
      end
   end

   // Rate in hundredths of hertz by reciprocal multiply, saturated.
   always_comb begin
      rate_prod = RATE_PROD_W'(rate_status.rate_acc) * RATE_PROD_W'(RATE_MUL);
      rate_quot = rate_prod[RATE_PROD_W-1:RATE_FRAC_W];
      rate_event_scale : begin
         rsp_event_rate_in = (|rate_quot[QUOT_W-1:RATE_W]) ?
                             '1 : rate_quot[RATE_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= state_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_valid_ff && out_advance) begin
         rsp_event_active_ff   <= filter_status.detected;
         rsp_raw_level_ff      <= filter_status.level;
         rsp_baseline_level_ff <= filter_status.baseline;
         rsp_event_rate_ff     <= rsp_event_rate_in;
         rsp_second_done_ff    <= rate_status.second_done;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_active   = rsp_event_active_ff;
   assign rsp_raw_level      = rsp_raw_level_ff;
   assign rsp_baseline_level = rsp_baseline_level_ff;
   assign rsp_event_rate     = rsp_event_rate_ff;
   assign rsp_second_done    = rsp_second_done_ff;

endmodule

/* design/csed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capacitive sense event detector port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module csed_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_event_active,
   input  logic [csed_pkg::LEVEL_W-1:0]       rsp_raw_level,
   input  logic [csed_pkg::LEVEL_W-1:0]       rsp_baseline_level,
   input  logic [csed_pkg::RATE_W-1:0]        rsp_event_rate,
   input  logic                               rsp_second_done
);
   import csed_pkg::*;

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   // A stalled result word stays valid and unchanged.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_active)
         && $stable(rsp_raw_level) && $stable(rsp_baseline_level)
         && $stable(rsp_event_rate) && $stable(rsp_second_done))
      else $error("result word changed while stalled");

   // Reset empties the output register.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the result side free, an accepted word reaches the output.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_accept ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word did not reach the output");

   // The input side is never stalled while the output register is empty.
   a_no_stall_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output register");

endmodule

bind cap_sense_event_rate_detector csed_checker u_csed_checker (.*);
